/* hw/rtl/rls_pkg.sv */
// Shared types and constants of the reservoir line sampler.
// No dependencies; imported by rls_datapath, rls_ctrl and the top level.
package rls_pkg;

    localparam logic [31:0] LCG_MUL   = 32'd1103515245;
    localparam logic [31:0] LCG_INC   = 32'd12345;
    localparam logic [7:0]  CHAR_LF   = 8'd10;
    localparam logic [7:0]  CHAR_CR   = 8'd13;
    localparam logic [15:0] LINES_MAX = 16'hFFFF;

    localparam int unsigned SEED_W = 32;
    localparam int unsigned MAXC_W = 9;

    // configuration register indexes
    localparam logic CFG_SEED     = 1'b0;
    localparam logic CFG_MAX_COPY = 1'b1;

    localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;
    localparam logic [MAXC_W-1:0] MAXC_RESET = 9'd128;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // input transfer this cycle
        logic gen_step;  // step the generator, start the modulo
        logic report;    // load result register, clear stream state
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic line_end;  // accepted byte closes a non-empty line
        logic is_last;   // accepted byte is the stream's last
        logic div_done;  // final modulo step this cycle
        logic out_free;  // result register can take a new result
    } t_sts;

endpackage

/* hw/rtl/rls_div.sv */
// Restoring remainder unit, one quotient bit per cycle.
// Depends on nothing but its ports; used by rls_datapath.
module rls_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic        o_rem_zero
);
    logic [30:0] r_quo;
    logic [15:0] r_rem;
    logic [15:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [16:0] w_trial;
    logic [15:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[30]};
        if (w_trial >= {1'b0, r_dvs}) begin
            n_rem = 16'(w_trial - {1'b0, r_dvs});
        end else begin
            n_rem = w_trial[15:0];
        end
    end

    assign o_done     = r_busy && (r_cnt == 5'd0);
    assign o_rem_zero = (n_rem == 16'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd30;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= 16'd0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[29:0], 1'b0};
            r_rem <= n_rem;
        end
    end
endmodule

/* hw/rtl/rls_datapath.sv */
// Datapath: stream state, generator, pick registers, result register.
// Depends on rls_pkg and rls_div.
module rls_datapath #(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rls_pkg::t_cmd                 i_cmd,
    output rls_pkg::t_sts                 o_sts,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [rls_pkg::SEED_W-1:0]    i_cfg_data,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_found,
    output logic [15:0]                   o_pick_start,
    output logic [7:0]                    o_pick_length,
    output logic [15:0]                   o_line_count,
    output logic                          o_overflow
);
    import rls_pkg::*;

    localparam int unsigned OB = OFFSET_BITS;
    localparam int unsigned LW = (OB + 1 > 16) ? OB + 1 : 16;
    localparam logic [OB-1:0] OFS_MAX = {OB{1'b1}};

    logic [31:0]       r_gen;
    logic [MAXC_W-1:0] r_max_copy;
    logic [15:0]       r_lines;
    logic [OB-1:0]     r_offset;
    logic [OB-1:0]     r_cur_start;
    logic              r_inside;
    logic [OB-1:0]     r_chosen_start;
    logic [15:0]       r_chosen_len;
    logic [15:0]       r_pend_len;
    logic              r_ovf;
    logic              r_out_valid;

    logic              w_term;
    logic [OB-1:0]     w_start_eff;
    logic [LW-1:0]     w_end;
    logic [15:0]       w_len;
    logic [31:0]       n_gen;
    logic              w_div_done;
    logic              w_rem_zero;
    logic [MAXC_W-1:0] w_lim9;
    logic [7:0]        w_lim8;
    logic [7:0]        w_clip;
    logic [LW-1:0]     w_start_ext;

    assign w_term      = (i_data_byte == CHAR_LF) || (i_data_byte == CHAR_CR);
    assign w_start_eff = (!w_term && !r_inside) ? r_offset : r_cur_start;
    // line end: at the terminator, or one past the last byte
    assign w_end = w_term ? LW'(r_offset) : LW'(r_offset) + LW'(1);
    assign w_len = 16'(w_end - LW'(w_start_eff));
    assign n_gen = (r_gen * LCG_MUL) + LCG_INC;

    assign w_lim9 = (r_max_copy == '0) ? '0 : r_max_copy - MAXC_W'(1);
    assign w_lim8 = (w_lim9 > MAXC_W'(255)) ? 8'hFF : w_lim9[7:0];
    assign w_clip = (r_chosen_len > {8'd0, w_lim8}) ? w_lim8 : r_chosen_len[7:0];
    assign w_start_ext = LW'(r_chosen_start);

    assign o_sts.line_end = w_term ? r_inside : i_last;
    assign o_sts.is_last  = i_last;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;

    rls_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.gen_step),
        .i_dividend (n_gen[31:1]),
        .i_divisor  (r_lines),
        .o_done     (w_div_done),
        .o_rem_zero (w_rem_zero)
    );

    // configuration and generator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen      <= SEED_RESET;
            r_max_copy <= MAXC_RESET;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SEED: begin
                        r_gen <= (i_cfg_data == '0) ? SEED_RESET : i_cfg_data;
                    end
                    CFG_MAX_COPY: begin
                        r_max_copy <= i_cfg_data[MAXC_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.gen_step) begin
                r_gen <= n_gen;
            end
        end
    end

    // stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.report) begin
            r_lines        <= '0;
            r_offset       <= '0;
            r_cur_start    <= '0;
            r_inside       <= 1'b0;
            r_chosen_start <= '0;
            r_chosen_len   <= '0;
            r_pend_len     <= '0;
            r_ovf          <= 1'b0;
        end else if (i_cmd.accept) begin
            if (r_offset == OFS_MAX) begin
                r_ovf <= 1'b1;
            end else begin
                r_offset <= r_offset + OB'(1);
            end
            r_cur_start <= w_start_eff;
            if (o_sts.line_end) begin
                r_inside   <= 1'b0;
                r_pend_len <= w_len;
                if (r_lines != LINES_MAX) begin
                    r_lines <= r_lines + 16'd1;
                end
            end else if (!w_term) begin
                r_inside <= 1'b1;
            end
        end else if (w_div_done && w_rem_zero) begin
            r_chosen_start <= r_cur_start;
            r_chosen_len   <= r_pend_len;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.report) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            o_found      <= (r_lines != 16'd0);
            o_pick_start <= (r_lines != 16'd0) ? w_start_ext[15:0] : 16'd0;
            o_pick_length <= (r_lines != 16'd0) ? w_clip : 8'd0;
            o_line_count <= r_lines;
            o_overflow   <= r_ovf;
        end
    end
endmodule

/* hw/rtl/rls_ctrl.sv */
// Controller state machine: input handshake and sequencing of line ends.
// Depends on rls_pkg.
module rls_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rls_pkg::t_sts i_sts,
    output rls_pkg::t_cmd o_cmd
);
    import rls_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GEN,
        S_DIV,
        S_RPT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    logic   r_last, n_last;

    assign o_in_ready     = r_in_ready;
    assign o_cmd.accept   = i_in_valid && r_in_ready;
    assign o_cmd.gen_step = (r_state == S_GEN);
    assign o_cmd.report   = (r_state == S_RPT) && i_sts.out_free;

    always_comb begin
        n_state    = r_state;
        n_last     = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.accept) begin
                    n_last = i_sts.is_last;
                    if (i_sts.line_end) begin
                        n_state = S_GEN;
                    end else if (i_sts.is_last) begin
                        n_state = S_RPT;
                    end
                end
            end
            S_GEN: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = r_last ? S_RPT : S_IDLE;
                end
            end
            S_RPT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
            r_last     <= n_last;
        end
    end
endmodule

/* hw/rtl/reservoir_line_sampler.sv */
// Top level of the reservoir line sampler.
// Depends on rls_pkg, rls_ctrl and rls_datapath (which holds rls_div).
//
// Picks one non-empty line of a byte stream at random (reservoir sampling).
// Input channel: one text byte per transfer (i_data_byte, i_last), valid/ready.
// LF and CR end a line; runs of them are skipped. The last byte also ends
// any open line.
// Output channel: one result per stream, sent after the byte with i_last:
// found, start offset of the pick, its length clipped to max_copy - 1
// (and 255), line count, and the offset saturation flag.
// Config port: i_cfg_we/i_cfg_index/i_cfg_data, index 0 seed (zero loads
// one), index 1 max_copy. Write only while the block is idle.
// Input: ordinary bytes are taken back to back. A byte that closes a line
// is followed by the generator multiply-add and the bit-serial remainder
// of the 31-bit draw by the line count; input is held off meanwhile.
// After the last byte the result register is loaded as soon as it is free,
// and o_out_valid is then set.
// Result register: the next stream's bytes are taken while a result waits;
// a further last byte is taken, but its result waits, with input held off, until the receiver takes the old result.
// Reset: seed 1, max_copy 128, stream state cleared, no result pending.
// The generator runs on across streams.
module reservoir_line_sampler #(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_found,
    output logic [15:0] o_pick_start,
    output logic [7:0]  o_pick_length,
    output logic [15:0] o_line_count,
    output logic        o_overflow
);
    import rls_pkg::*;

    t_cmd s_cmd;
    t_sts s_sts;

    rls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    rls_datapath #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .o_sts         (s_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_data_byte   (i_data_byte),
        .i_last        (i_last),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_found       (o_found),
        .o_pick_start  (o_pick_start),
        .o_pick_length (o_pick_length),
        .o_line_count  (o_line_count),
        .o_overflow    (o_overflow)
    );

    // no byte is taken while the generator steps
    a_no_accept_in_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.gen_step |-> !s_cmd.accept)
        else $error("byte accepted during generator step");

    // input is still held off in the final modulo step
    a_div_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_sts.div_done |-> !o_in_ready)
        else $error("input ready while modulo runs");

    // a generator step is always followed by a busy input side
    a_gen_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.gen_step |=> !o_in_ready)
        else $error("input ready right after generator step");

    // empty text reports a zero pick
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |->
            (o_pick_start == 16'd0 && o_pick_length == 8'd0 && o_line_count == 16'd0))
        else $error("non-zero pick for empty text");
endmodule
